// ----- rtl/rmvig_pkg.sv -----
// Shared types and constants for the ring mesh vertex and index generator.
`timescale 1ns / 1ps
package rmvig_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_LEN         = 24;
	localparam int MAX_VERTICES     = 65535;
	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);

	localparam int THETA_NUM_W = 37;
	localparam int RAD_NUM_W   = 41;
	localparam int TEX_NUM_W   = 56;
	localparam int DIV_Q_W     = 24;
	localparam int TEX_Q_W     = 32;

	localparam logic [36:0] Q30_TWO_PI     = 37'd6746518852;
	localparam logic [32:0] Q30_PI         = 33'd3373259426;
	localparam logic [32:0] Q30_HALF_PI    = 33'd1686629713;
	localparam logic [32:0] Q30_FOLD_LIMIT = 33'd5059889139;
	localparam logic signed [32:0] Q30_GAIN_INV = 33'sd652032875;

	localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
		30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
	};

	typedef enum logic [2:0] {
		ST_OK,
		ST_FEW_ANG,
		ST_FEW_RAD,
		ST_RADII,
		ST_TOO_MANY,
		ST_OUT_GRID
	} status_t;

	typedef enum logic [2:0] {
		REG_INNER,
		REG_OUTER,
		REG_ANG_SEG,
		REG_RAD_SEG,
		REG_START,
		REG_SWEEP
	} reg_idx_t;

	typedef struct packed {
		logic [23:0]        inner;
		logic [23:0]        outer;
		logic [15:0]        ang_seg;
		logic [15:0]        rad_seg;
		logic signed [20:0] start;
		logic signed [20:0] sweep;
	} cfg_t;

	typedef struct packed {
		logic        vld;
		status_t     status;
		logic        cell_ok;
		logic [15:0] idx_a;
	} side_t;

	typedef struct packed {
		side_t                  side;
		logic                   theta_neg;
		logic [THETA_NUM_W-1:0] theta_num;
		logic [RAD_NUM_W-1:0]   rad_num;
	} item_t;

endpackage

// ----- rtl/rmvig_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
module rmvig_div #(
	parameter int NUM_W  = 37,
	parameter int DEN_W  = 16,
	parameter int Q_W    = 24,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic [Q_W-1:0]    q,
	output logic [SIDE_W-1:0] side_out
);

	logic [DEN_W-1:0]  rem_s  [Q_W];
	logic [Q_W-1:0]    low_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic [DEN_W-1:0]  rem_p  [Q_W];
	logic [Q_W-1:0]    low_p  [Q_W];
	logic [DEN_W-1:0]  rem_n  [Q_W];
	logic [Q_W-1:0]    low_n  [Q_W];
	logic [DEN_W:0]    trial;
	logic              ge;

	always_comb begin
		rem_p[0] = DEN_W'(num[NUM_W-1:Q_W]);
		low_p[0] = num[Q_W-1:0];
		for (int k = 1; k < Q_W; k++) begin
			rem_p[k] = rem_s[k-1];
			low_p[k] = low_s[k-1];
		end
		trial = '0;
		ge    = 1'b0;
		for (int k = 0; k < Q_W; k++) begin
			trial    = {rem_p[k], low_p[k][Q_W-1]};
			ge       = trial >= {1'b0, den};
			rem_n[k] = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
			low_n[k] = {low_p[k][Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k] <= rem_n[k];
				low_s[k] <= low_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Q_W; k++) side_s[k] <= '0;
		end else if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < Q_W; k++) side_s[k] <= side_s[k-1];
		end
	end

	assign q        = low_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

// ----- rtl/rmvig_front.sv -----
// Front end: accept grid steps, check settings, form divider numerators and corner index.
`timescale 1ns / 1ps
module rmvig_front import rmvig_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] angular_step,
	input  logic [15:0] radial_step,
	input  logic        full,
	output logic        push,
	output item_t       item
);

	logic        v_s1;
	logic [15:0] i_s1;
	logic [15:0] j_s1;
	logic [33:0] nverts;
	logic [20:0] sweep_mag;
	logic [23:0] diff;
	logic [32:0] idx_w;
	status_t     st;

	assign in_ready = !v_s1 || !full;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			i_s1 <= angular_step;
			j_s1 <= radial_step;
		end
	end

	always_comb begin
		nverts = ({1'b0, cfg.ang_seg} + 17'd1) * ({1'b0, cfg.rad_seg} + 17'd1);
		if (cfg.ang_seg < 16'd3) st = ST_FEW_ANG;
		else if (cfg.rad_seg < 16'd1) st = ST_FEW_RAD;
		else if (cfg.inner >= cfg.outer) st = ST_RADII;
		else if (nverts > 34'(MAX_VERTICES)) st = ST_TOO_MANY;
		else if (i_s1 > cfg.ang_seg || j_s1 > cfg.rad_seg) st = ST_OUT_GRID;
		else st = ST_OK;

		sweep_mag = cfg.sweep[20] ? 21'(-cfg.sweep) : 21'(cfg.sweep);
		diff      = cfg.outer - cfg.inner;
		idx_w     = 33'(i_s1 * ({1'b0, cfg.rad_seg} + 17'd1)) + 33'(j_s1);

		item.side.vld     = 1'b1;
		item.side.status  = st;
		item.side.cell_ok = (st == ST_OK) && (i_s1 < cfg.ang_seg) && (j_s1 < cfg.rad_seg);
		item.side.idx_a   = idx_w[15:0];
		item.theta_neg    = cfg.sweep[20];
		item.theta_num    = THETA_NUM_W'(i_s1 * sweep_mag) + THETA_NUM_W'(cfg.ang_seg >> 1);
		item.rad_num      = RAD_NUM_W'(j_s1 * diff) + RAD_NUM_W'(cfg.rad_seg >> 1);
	end

endmodule

// ----- rtl/rmvig_fifo.sv -----
// Short request queue between the front end and the vertex pipeline.
`timescale 1ns / 1ps
module rmvig_fifo import rmvig_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output item_t dout,
	output logic  empty
);

	item_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_PTR_W:0]   cnt_q;

	assign full  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/rmvig_back.sv -----
// Back end: angle and radius division, angle reduction, CORDIC, position, uv and index output.
`timescale 1ns / 1ps
module rmvig_back import rmvig_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  item_t              item,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output status_t            status,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               cell_valid,
	output logic [15:0]        index_0,
	output logic [15:0]        index_1,
	output logic [15:0]        index_2,
	output logic [15:0]        index_3,
	output logic [15:0]        index_4,
	output logic [15:0]        index_5
);

	localparam int SIDE_W = $bits(side_t);
	localparam int TU_W   = SIDE_W + 26;
	localparam logic signed [39:0] ANG_OFFS = 40'sd40479113112;

	logic                en;
	side_t               side_in;
	logic [DIV_Q_W-1:0]  th_q;
	logic [DIV_Q_W-1:0]  rd_q;
	logic [SIDE_W-1:0]   th_side;
	logic                rd_neg;
	side_t               th_sd;

	logic signed [25:0]  th_w;
	logic signed [39:0]  ang_w;
	side_t               side_s1;
	logic [36:0]         ang_s1;
	logic [23:0]         r_s1;

	logic [36:0]         red_p [4];
	logic [36:0]         red_n [4];
	logic [36:0]         red_s [4];
	logic [23:0]         r_red [4];
	side_t               side_red [4];

	logic [32:0]         m_w;
	logic signed [33:0]  z_w;
	logic                neg_w;

	logic signed [32:0]  x_c [CORDIC_STEPS+1];
	logic signed [32:0]  y_c [CORDIC_STEPS+1];
	logic signed [33:0]  z_c [CORDIC_STEPS+1];
	logic                neg_c [CORDIC_STEPS+1];
	logic [23:0]         r_c [CORDIC_STEPS+1];
	side_t               side_c [CORDIC_STEPS+1];
	logic signed [32:0]  x_n [CORDIC_STEPS];
	logic signed [32:0]  y_n [CORDIC_STEPS];
	logic signed [33:0]  z_n [CORDIC_STEPS];

	logic signed [57:0]  px_s7;
	logic signed [57:0]  py_s7;
	logic                neg_s7;
	side_t               side_s7;

	logic signed [57:0]  pcx;
	logic signed [57:0]  pcy;
	logic [56:0]         magx;
	logic [56:0]         magy;
	side_t               side_s8;
	logic [24:0]         posx_s8;
	logic [24:0]         posy_s8;
	logic [TEX_NUM_W-1:0] tnx_s8;
	logic [TEX_NUM_W-1:0] tny_s8;
	logic                sgx_s8;
	logic                sgy_s8;

	logic [TEX_Q_W-1:0]  tu_q;
	logic [TEX_Q_W-1:0]  tv_q;
	logic [TU_W-1:0]     tu_side;
	logic [25:0]         tv_side;
	side_t               side_f;
	logic [24:0]         posx_f;
	logic [24:0]         posy_f;
	logic                sgx_f;
	logic                sgy_f;
	logic                ok_f;
	logic                cell_f;
	logic [15:0]         d_f;

	function automatic logic [24:0] pos_fin(input logic [56:0] mag, input logic neg);
		logic [27:0] q;
		q = 28'((mag + 57'd536870912) >> 30);
		if (!neg) pos_fin = (q > 28'd16777215) ? 25'h0FFFFFF : 25'(q);
		else pos_fin = (q > 28'd16777216) ? 25'h1000000 : 25'(-q);
	endfunction

	function automatic logic [16:0] tex_fin(input logic [TEX_Q_W-1:0] q, input logic neg);
		logic signed [34:0] t;
		logic [33:0]        mag;
		logic [19:0]        qq;
		t   = (neg ? -$signed({3'b0, q}) : $signed({3'b0, q})) + 35'sd1073741824;
		mag = t[34] ? 34'(-t) : t[33:0];
		qq  = 20'((mag + 34'd16384) >> 15);
		if (t[34]) tex_fin = 17'd0;
		else if (qq > 20'd65536) tex_fin = 17'd65536;
		else tex_fin = qq[16:0];
	endfunction

	assign en  = !out_valid || out_ready;
	assign pop = en && !empty;

	always_comb begin
		side_in     = item.side;
		side_in.vld = !empty;
	end

	rmvig_div #(
		.NUM_W(THETA_NUM_W), .DEN_W(16), .Q_W(DIV_Q_W), .SIDE_W(SIDE_W)
	) u_th_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(item.theta_num), .den(cfg.ang_seg), .side_in(side_in),
		.q(th_q), .side_out(th_side)
	);

	rmvig_div #(
		.NUM_W(RAD_NUM_W), .DEN_W(16), .Q_W(DIV_Q_W), .SIDE_W(1)
	) u_rd_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(item.rad_num), .den(cfg.rad_seg), .side_in(item.theta_neg),
		.q(rd_q), .side_out(rd_neg)
	);

	assign th_sd = side_t'(th_side);

	always_comb begin
		th_w  = $signed(cfg.start) +
			(rd_neg ? -$signed({1'b0, th_q}) : $signed({1'b0, th_q}));
		ang_w = (40'(th_w) <<< 14) + ANG_OFFS;
	end

	always_comb begin
		red_p[0] = ang_s1;
		for (int k = 1; k < 4; k++) red_p[k] = red_s[k-1];
		for (int k = 0; k < 4; k++) begin
			if (red_p[k] >= (Q30_TWO_PI << (3 - k))) red_n[k] = red_p[k] - (Q30_TWO_PI << (3 - k));
			else red_n[k] = red_p[k];
		end
	end

	// fold into [-pi/2, pi/2], negate the result later when folded by pi
	always_comb begin
		m_w = red_s[3][32:0];
		if (m_w <= Q30_HALF_PI) begin
			z_w   = $signed({1'b0, m_w});
			neg_w = 1'b0;
		end else if (m_w < Q30_FOLD_LIMIT) begin
			z_w   = $signed({1'b0, m_w}) - $signed({1'b0, Q30_PI});
			neg_w = 1'b1;
		end else begin
			z_w   = $signed({1'b0, m_w}) - $signed(34'(Q30_TWO_PI));
			neg_w = 1'b0;
		end
	end

	always_comb begin
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (z_c[k] >= 0) begin
				x_n[k] = x_c[k] - (y_c[k] >>> k);
				y_n[k] = y_c[k] + (x_c[k] >>> k);
				z_n[k] = z_c[k] - $signed({4'b0, ATAN_Q30[k]});
			end else begin
				x_n[k] = x_c[k] + (y_c[k] >>> k);
				y_n[k] = y_c[k] - (x_c[k] >>> k);
				z_n[k] = z_c[k] + $signed({4'b0, ATAN_Q30[k]});
			end
		end
	end

	always_comb begin
		pcx  = neg_s7 ? -px_s7 : px_s7;
		pcy  = neg_s7 ? -py_s7 : py_s7;
		magx = pcx[57] ? 57'(-pcx) : pcx[56:0];
		magy = pcy[57] ? 57'(-pcy) : pcy[56:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_w[36:0];
			r_s1   <= cfg.inner + rd_q[23:0];
			for (int k = 0; k < 4; k++) red_s[k] <= red_n[k];
			r_red[0] <= r_s1;
			for (int k = 1; k < 4; k++) r_red[k] <= r_red[k-1];
			x_c[0]   <= Q30_GAIN_INV;
			y_c[0]   <= '0;
			z_c[0]   <= z_w;
			neg_c[0] <= neg_w;
			r_c[0]   <= r_red[3];
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				x_c[k+1]   <= x_n[k];
				y_c[k+1]   <= y_n[k];
				z_c[k+1]   <= z_n[k];
				neg_c[k+1] <= neg_c[k];
				r_c[k+1]   <= r_c[k];
			end
			px_s7   <= $signed({1'b0, r_c[CORDIC_STEPS]}) * x_c[CORDIC_STEPS];
			py_s7   <= $signed({1'b0, r_c[CORDIC_STEPS]}) * y_c[CORDIC_STEPS];
			neg_s7  <= neg_c[CORDIC_STEPS];
			posx_s8 <= pos_fin(magx, pcx[57]);
			posy_s8 <= pos_fin(magy, pcy[57]);
			tnx_s8  <= TEX_NUM_W'(magx + 57'(cfg.outer >> 1));
			tny_s8  <= TEX_NUM_W'(magy + 57'(cfg.outer >> 1));
			sgx_s8  <= pcx[57];
			sgy_s8  <= pcy[57];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			for (int k = 0; k < 4; k++) side_red[k] <= '0;
			for (int k = 0; k <= CORDIC_STEPS; k++) side_c[k] <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
		end else if (en) begin
			side_s1     <= th_sd;
			side_red[0] <= side_s1;
			for (int k = 1; k < 4; k++) side_red[k] <= side_red[k-1];
			side_c[0] <= side_red[3];
			for (int k = 0; k < CORDIC_STEPS; k++) side_c[k+1] <= side_c[k];
			side_s7 <= side_c[CORDIC_STEPS];
			side_s8 <= side_s7;
		end
	end

	rmvig_div #(
		.NUM_W(TEX_NUM_W), .DEN_W(24), .Q_W(TEX_Q_W), .SIDE_W(TU_W)
	) u_tu_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(tnx_s8), .den(cfg.outer), .side_in({side_s8, posx_s8, sgx_s8}),
		.q(tu_q), .side_out(tu_side)
	);

	rmvig_div #(
		.NUM_W(TEX_NUM_W), .DEN_W(24), .Q_W(TEX_Q_W), .SIDE_W(26)
	) u_tv_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(tny_s8), .den(cfg.outer), .side_in({posy_s8, sgy_s8}),
		.q(tv_q), .side_out(tv_side)
	);

	always_comb begin
		{side_f, posx_f, sgx_f} = tu_side;
		{posy_f, sgy_f}         = tv_side;
		ok_f   = side_f.status == ST_OK;
		cell_f = ok_f && side_f.cell_ok;
		d_f    = side_f.idx_a + cfg.rad_seg + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= side_f.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status     <= side_f.status;
			pos_x      <= ok_f ? posx_f : '0;
			pos_y      <= ok_f ? posy_f : '0;
			tex_u      <= ok_f ? tex_fin(tu_q, sgx_f) : '0;
			tex_v      <= ok_f ? tex_fin(tv_q, sgy_f) : '0;
			cell_valid <= cell_f;
			index_0    <= cell_f ? side_f.idx_a : '0;
			index_1    <= cell_f ? side_f.idx_a + 16'd1 : '0;
			index_2    <= cell_f ? d_f + 16'd1 : '0;
			index_3    <= cell_f ? side_f.idx_a : '0;
			index_4    <= cell_f ? d_f + 16'd1 : '0;
			index_5    <= cell_f ? d_f : '0;
		end
	end

endmodule

// ----- rtl/ring_mesh_vertex_index_generator.sv -----
// Top level of the ring mesh vertex and index generator with its register port.
//
//  channel  | dir | payload                                          | handshake
//  s_axis   | in  | tdata: angular_step[15:0], radial_step[31:16]    | tvalid/tready
//  m_axis   | out | tdata: pos, uv, six indices; tuser: status, cell | tvalid/tready
//  apb      | in  | 6 registers at byte address 4*i, 32-bit data      | psel/penable
//
//  One grid point per cycle sustained while m_axis is not stalled; latency is set by
//  the angle/radius dividers, the CORDIC chain and the uv dividers.
//  Reset clears all valid state; registers return to their reset defaults.
//  A stalled output freezes the whole vertex pipeline; the front end keeps taking
//  requests into a four-entry queue until it fills.
`timescale 1ns / 1ps
module ring_mesh_vertex_index_generator import rmvig_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // angular_step, radial_step
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x, pos_y, tex_u, tex_v, index_0..index_5, zero pad
	output logic [183:0] m_axis_tdata,
	output logic [3:0]   m_axis_tuser,   // status, cell_valid
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t               cfg_q;
	reg_idx_t           ridx;
	logic               push;
	logic               full;
	logic               pop;
	logic               empty;
	item_t              fr_item;
	item_t              fi_item;
	status_t            status;
	logic signed [24:0] pos_x;
	logic signed [24:0] pos_y;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic               cell_valid;
	logic [15:0]        index_0;
	logic [15:0]        index_1;
	logic [15:0]        index_2;
	logic [15:0]        index_3;
	logic [15:0]        index_4;
	logic [15:0]        index_5;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inner   <= 24'd32768;
			cfg_q.outer   <= 24'd65536;
			cfg_q.ang_seg <= 16'd32;
			cfg_q.rad_seg <= 16'd1;
			cfg_q.start   <= 21'sd0;
			cfg_q.sweep   <= 21'sd411775;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_INNER:   cfg_q.inner   <= pwdata[23:0];
				REG_OUTER:   cfg_q.outer   <= pwdata[23:0];
				REG_ANG_SEG: cfg_q.ang_seg <= pwdata[15:0];
				REG_RAD_SEG: cfg_q.rad_seg <= pwdata[15:0];
				REG_START:   cfg_q.start   <= $signed(pwdata[20:0]);
				REG_SWEEP:   cfg_q.sweep   <= $signed(pwdata[20:0]);
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_INNER:   prdata = {8'd0, cfg_q.inner};
			REG_OUTER:   prdata = {8'd0, cfg_q.outer};
			REG_ANG_SEG: prdata = {16'd0, cfg_q.ang_seg};
			REG_RAD_SEG: prdata = {16'd0, cfg_q.rad_seg};
			REG_START:   prdata = {11'd0, cfg_q.start};
			REG_SWEEP:   prdata = {11'd0, cfg_q.sweep};
			default:     prdata = '0;
		endcase
	end

	rmvig_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.angular_step(s_axis_tdata[15:0]), .radial_step(s_axis_tdata[31:16]),
		.full(full), .push(push), .item(fr_item)
	);

	rmvig_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(fr_item), .full(full),
		.pop(pop), .dout(fi_item), .empty(empty)
	);

	rmvig_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item(fi_item), .empty(empty), .pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(status), .pos_x(pos_x), .pos_y(pos_y),
		.tex_u(tex_u), .tex_v(tex_v), .cell_valid(cell_valid),
		.index_0(index_0), .index_1(index_1), .index_2(index_2),
		.index_3(index_3), .index_4(index_4), .index_5(index_5)
	);

	assign m_axis_tuser = {cell_valid, status};
	assign m_axis_tdata = {4'd0, index_5, index_4, index_3, index_2, index_1, index_0,
		tex_v, tex_u, pos_y, pos_x};

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the ring mesh vertex and index generator.
`timescale 1ns / 1ps
module tb;
	import rmvig_pkg::*;

	localparam logic [4:0] ADDR_UNUSED = 5'd24;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		status_t status;
		longint  pos_x, pos_y, tex_u, tex_v;
		bit      cell_ok;
		longint  idx [6];
	} vertex_t;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, m_axis_tready = 0;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tready, m_axis_tvalid, pready;
	logic [183:0] m_axis_tdata;
	logic [3:0] m_axis_tuser;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;

	longint inner_r, outer_r, ang_seg, rad_seg, start_a, sweep_a;
	vertex_t vertex_q [$];
	int errors = 0;
	bit no_idle = 0;
	int stall = 0;

	ring_mesh_vertex_index_generator uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint q;
		q = ((n < 0 ? -n : n) + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic void cordic_q30(input longint ang, output longint c, output longint s);
		longint m, x, y, z, xs, ys;
		bit flip;
		m = ang % 64'sd6746518852;
		flip = 0;
		x = 652032875;
		y = 0;
		if (m < 0) m += 64'sd6746518852;
		if (m > 64'sd3373259426) m -= 64'sd6746518852;
		if (m > 64'sd1686629713) begin
			m -= 64'sd3373259426;
			flip = 1;
		end else if (m < -64'sd1686629713) begin
			m += 64'sd3373259426;
			flip = 1;
		end
		z = m;
		for (int k = 0; k < CORDIC_STEPS_DEF; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= longint'(ATAN_Q30[k]);
			end else begin
				x += ys;
				y -= xs;
				z += longint'(ATAN_Q30[k]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint sat_pos(longint r, longint t);
		longint p;
		p = round_div(r * t, 64'sd1073741824);
		if (p > 16777215) p = 16777215;
		if (p < -16777216) p = -16777216;
		return p;
	endfunction

	function automatic longint tex_coord(longint r, longint t);
		longint u;
		u = round_div(round_div(t * r, outer_r) + 64'sd1073741824, 32768);
		if (u < 0) u = 0;
		if (u > 65536) u = 65536;
		return u;
	endfunction

	function automatic vertex_t predict_vertex(longint i, longint j);
		vertex_t v;
		longint theta, r, c, s, a, d;
		v.status = ST_OK;
		v.pos_x = 0; v.pos_y = 0; v.tex_u = 0; v.tex_v = 0; v.cell_ok = 0;
		foreach (v.idx[k]) v.idx[k] = 0;
		if (ang_seg < 3) v.status = ST_FEW_ANG;
		else if (rad_seg < 1) v.status = ST_FEW_RAD;
		else if (inner_r >= outer_r) v.status = ST_RADII;
		else if ((ang_seg + 1) * (rad_seg + 1) > MAX_VERTICES) v.status = ST_TOO_MANY;
		else if (i > ang_seg || j > rad_seg) v.status = ST_OUT_GRID;
		if (v.status != ST_OK) return v;
		theta = start_a + round_div(i * sweep_a, ang_seg);
		r = inner_r + (j * (outer_r - inner_r) + rad_seg / 2) / rad_seg;
		cordic_q30(theta * 16384, c, s);
		v.pos_x = sat_pos(r, c);
		v.pos_y = sat_pos(r, s);
		v.tex_u = tex_coord(r, c);
		v.tex_v = tex_coord(r, s);
		if (i < ang_seg && j < rad_seg) begin
			a = (i * (rad_seg + 1) + j) & 16'hFFFF;
			d = ((i + 1) * (rad_seg + 1) + j) & 16'hFFFF;
			v.cell_ok = 1;
			v.idx[0] = a; v.idx[1] = (a + 1) & 16'hFFFF; v.idx[2] = (d + 1) & 16'hFFFF;
			v.idx[3] = a; v.idx[4] = (d + 1) & 16'hFFFF; v.idx[5] = d;
		end
		return v;
	endfunction

	task automatic apb_write(logic [4:0] addr, longint value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (addr)
			4 * REG_INNER:   inner_r = value & 24'hFFFFFF;
			4 * REG_OUTER:   outer_r = value & 24'hFFFFFF;
			4 * REG_ANG_SEG: ang_seg = value & 16'hFFFF;
			4 * REG_RAD_SEG: rad_seg = value & 16'hFFFF;
			4 * REG_START:   start_a = longint'(signed'(value[20:0]));
			4 * REG_SWEEP:   sweep_a = longint'(signed'(value[20:0]));
			default: ;
		endcase
	endtask

	task automatic set_ring(longint inn, longint out, longint a, longint r, longint st, longint sw);
		apb_write(4 * REG_INNER, inn);
		apb_write(4 * REG_OUTER, out);
		apb_write(4 * REG_ANG_SEG, a);
		apb_write(4 * REG_RAD_SEG, r);
		apb_write(4 * REG_START, st);
		apb_write(4 * REG_SWEEP, sw);
	endtask

	task automatic send_request(longint i, longint j);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {j[15:0], i[15:0]};
		do @(posedge clk); while (!s_axis_tready);
		vertex_q.push_back(predict_vertex(i & 16'hFFFF, j & 16'hFFFF));
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (no_idle) begin
			m_axis_tready <= 1;
		end else if (stall > 0) begin
			stall <= stall - 1;
			m_axis_tready <= 0;
		end else begin
			stall <= pick_gap();
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (vertex_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = vertex_q.pop_front();
				check_field("status", e.status, m_axis_tuser[2:0]);
				check_field("cell_valid", e.cell_ok, m_axis_tuser[3]);
				check_field("pos_x", e.pos_x, longint'(signed'(m_axis_tdata[24:0])));
				check_field("pos_y", e.pos_y, longint'(signed'(m_axis_tdata[49:25])));
				check_field("tex_u", e.tex_u, m_axis_tdata[66:50]);
				check_field("tex_v", e.tex_v, m_axis_tdata[83:67]);
				for (int k = 0; k < 6; k++)
					check_field($sformatf("index_%0d", k), e.idx[k],
						m_axis_tdata[84 + 16 * k +: 16]);
			end
		end
	end

	task automatic test_default_ring();
		no_idle = 1;
		send_request(0, 0);
		send_request(31, 0);
		send_request(32, 1);
		send_request(8, 1);
		no_idle = 0;
		send_request(33, 0);
		send_request(0, 2);
		send_request(65535, 65535);
		drain();
	endtask

	task automatic test_extremes();
		set_ring(0, 16777215, 3, 1, -1048576, 1048575);
		send_request(0, 0);
		send_request(3, 1);
		send_request(2, 0);
		send_request(1, 1);
		drain();
		set_ring(16777214, 16777215, 32766, 1, 1048575, -1048576);
		send_request(32766, 1);
		send_request(32765, 0);
		send_request(12345, 1);
		drain();
		apb_write(ADDR_UNUSED, 32'hFFFFFFFF);
		send_request(0, 1);
		drain();
	endtask

	task automatic test_faults();
		set_ring(32768, 65536, 2, 1, 0, 411775);
		send_request(0, 0);
		drain();
		apb_write(4 * REG_ANG_SEG, 3);
		apb_write(4 * REG_RAD_SEG, 0);
		send_request(0, 0);
		drain();
		apb_write(4 * REG_RAD_SEG, 1);
		apb_write(4 * REG_INNER, 65536);
		send_request(1, 0);
		drain();
		apb_write(4 * REG_INNER, 100);
		apb_write(4 * REG_ANG_SEG, 65535);
		send_request(1, 0);
		drain();
	endtask

	task automatic test_random_rings();
		longint a, r, o, i, j;
		for (int ph = 0; ph < 25; ph++) begin
			r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 8);
			a = $urandom_range(3, 65535 / (r + 1) - 1);
			if ($urandom_range(0, 1)) a = $urandom_range(3, 40);
			o = $urandom_range(1, 16777215);
			if ($urandom_range(0, 9) == 0)
				set_ring($urandom, $urandom, $urandom_range(0, 65535),
					$urandom_range(0, 3), $urandom, $urandom);
			else
				set_ring($urandom_range(0, o - 1), o, a, r, $urandom, $urandom);
			no_idle = (ph % 5 == 4);
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					i = $urandom_range(0, 65535);
					j = $urandom_range(0, 65535);
				end else begin
					i = $urandom_range(0, ang_seg + 1);
					j = $urandom_range(0, rad_seg + 1);
				end
				send_request(i, j);
			end
			no_idle = 0;
			drain();
		end
	endtask

	initial begin
		inner_r = 32768; outer_r = 65536; ang_seg = 32; rad_seg = 1;
		start_a = 0; sweep_a = 411775;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_default_ring();
		test_extremes();
		test_faults();
		test_random_rings();
		if (errors == 0 && vertex_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- ring_mesh_vertex_index_generator.f -----
rtl/rmvig_pkg.sv
rtl/rmvig_div.sv
rtl/rmvig_front.sv
rtl/rmvig_fifo.sv
rtl/rmvig_back.sv
rtl/ring_mesh_vertex_index_generator.sv
tb/sv/tb.sv
